// ===== hdl/rut_pkg.sv =====
package rut_pkg;

  // Widths fixed by the item and result formats.
  localparam int unsigned LABEL_W  = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned KEY_W    = LABEL_W + MODE_W + LABEL_W;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned WORD_W   = KEY_W + STAMP_W;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 8;

  // Action codes carried by an input item.
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Coverage mode that, together with label zero, marks a key to ignore.
  localparam logic [MODE_W-1:0] MODE_PAINT_ALL = 2'd0;

  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_READ_OOR  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_WRITE
  } state_e;

  typedef struct packed {
    logic               action;
    logic [LABEL_W-1:0] fore_label;
    logic [MODE_W-1:0]  coverage_mode;
    logic [LABEL_W-1:0] drawover_label;
    logic [SLOT_W-1:0]  entry_index;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [SIZE_W-1:0]  table_size;
    logic [LABEL_W-1:0] out_fore_label;
    logic [MODE_W-1:0]  out_coverage_mode;
    logic [LABEL_W-1:0] out_drawover_label;
  } result_t;

endpackage

// ===== hdl/recent_use_table_lru.sv =====
// Channel  | Ports                    | Direction | Handshake
// ---------+--------------------------+-----------+----------------------------------
// item     | start, busy, item_i      | in        | taken when start && !busy
// result   | done_o, result_o         | out       | valid for the single cycle of done_o
//
// A read item with a valid slot passes through the RAM read register and the S_READ state
// before its result is registered; an out-of-range read and an ignored record key are
// answered straight from idle. A record item scans the used slots, one slot read per cycle
// through the single read port, then checks the last slot, ends the scan and writes back.
// Reset leaves the table empty and the stamp counter at zero; no clearing pass. The receiver
// cannot stall.
module recent_use_table_lru #(
  parameter int unsigned TABLE_DEPTH = rut_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rut_pkg::item_t   item_i,
  output logic             done_o,
  output rut_pkg::result_t result_o
);
  import rut_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  state_e               state_q, state_d;
  item_t                item_q, item_d;
  logic [CNT_W-1:0]     addr_q, addr_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pidx_q, pidx_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic                 minv_q, minv_d;
  logic [STAMP_W-1:0]   min_stamp_q, min_stamp_d;
  logic [IDX_W-1:0]     min_idx_q, min_idx_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [STAMP_W-1:0]   ctr_q, ctr_d;
  logic                 done_q, done_d;
  result_t              res_q, res_d;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;

  logic                 accept;
  logic                 idx_in_range;
  logic                 key_ignored;
  logic                 scan_end;
  logic                 full;
  logic [KEY_W-1:0]     key_q;
  logic [KEY_W-1:0]     rd_key;
  logic [STAMP_W-1:0]   rd_stamp;

  rut_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Decoded conditions shared by the state and data logic.
  assign busy         = (state_q != S_IDLE);
  assign accept       = start && !busy;
  assign idx_in_range = ({1'b0, item_i.entry_index} < SIZE_W'(used_q));
  assign key_ignored  = (item_i.fore_label == '0) && (item_i.coverage_mode == MODE_PAINT_ALL);
  assign scan_end     = !pend_q && (addr_q >= used_q);
  assign full         = (used_q == CNT_W'(TABLE_DEPTH));
  assign key_q        = {item_q.fore_label, item_q.coverage_mode, item_q.drawover_label};
  assign rd_key       = mem_rdata[WORD_W-1:STAMP_W];
  assign rd_stamp     = mem_rdata[STAMP_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.action == ACT_READ) begin
            if (idx_in_range) begin
              state_d = S_READ;
            end
          end else if (!key_ignored) begin
            state_d = S_SCAN;
          end
        end
      end
      S_READ:  state_d = S_IDLE;
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory accesses, scan bookkeeping and results.
  always_comb begin
    item_d      = item_q;
    addr_d      = addr_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    minv_d      = minv_q;
    min_stamp_d = min_stamp_q;
    min_idx_d   = min_idx_q;
    used_d      = used_q;
    ctr_d       = ctr_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = {key_q, ctr_q};
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = item_i;
          addr_d = '0;
          hit_d  = 1'b0;
          minv_d = 1'b0;
          res_d  = '0;
          res_d.table_size = SIZE_W'(used_q);
          if (item_i.action == ACT_READ) begin
            res_d.slot = item_i.entry_index;
            if (idx_in_range) begin
              mem_re    = 1'b1;
              mem_raddr = item_i.entry_index[IDX_W-1:0];
            end else begin
              res_d.status = ST_READ_OOR;
              done_d       = 1'b1;
            end
          end else if (key_ignored) begin
            res_d.status = ST_IGNORED;
            done_d       = 1'b1;
          end
        end
      end

      S_READ: begin
        res_d.status             = ST_READ_OK;
        res_d.out_fore_label     = rd_key[KEY_W-1 -: LABEL_W];
        res_d.out_coverage_mode  = rd_key[LABEL_W +: MODE_W];
        res_d.out_drawover_label = rd_key[LABEL_W-1:0];
        done_d                   = 1'b1;
      end

      S_SCAN: begin
        // Issue the next slot's read while the previous slot's data is checked.
        if (addr_q < used_q) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q[IDX_W-1:0];
          addr_d    = CNT_W'(addr_q + 1'b1);
          pend_d    = 1'b1;
          pidx_d    = addr_q[IDX_W-1:0];
        end
        if (pend_q) begin
          if (!hit_q && (rd_key == key_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = pidx_q;
          end
          // Strictly smaller keeps the lowest slot on a tie.
          if (!minv_q || (rd_stamp < min_stamp_q)) begin
            minv_d      = 1'b1;
            min_stamp_d = rd_stamp;
            min_idx_d   = pidx_q;
          end
        end
      end

      S_WRITE: begin
        mem_we = 1'b1;
        ctr_d  = ctr_q + 1'b1;
        if (hit_q) begin
          mem_waddr    = hit_idx_q;
          res_d.status = ST_REFRESHED;
        end else if (!full) begin
          mem_waddr    = used_q[IDX_W-1:0];
          used_d       = CNT_W'(used_q + 1'b1);
          res_d.status = ST_APPENDED;
        end else begin
          mem_waddr    = min_idx_q;
          res_d.status = ST_REPLACED;
        end
        res_d.slot       = SLOT_W'(mem_waddr);
        res_d.table_size = SIZE_W'(used_d);
        done_d           = 1'b1;
      end

      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      addr_q  <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      minv_q  <= 1'b0;
      used_q  <= '0;
      ctr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      minv_q  <= minv_d;
      used_q  <= used_d;
      ctr_q   <= ctr_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pidx_q      <= pidx_d;
    hit_idx_q   <= hit_idx_d;
    min_stamp_q <= min_stamp_d;
    min_idx_q   <= min_idx_d;
    res_q       <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // The table never holds more entries than it has slots.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_DEPTH))
    else $error("table size beyond depth");

  // A result is always shown with the sequencer back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result shown while sequencer busy");

  // The stamp counter moves only with a write-back.
  a_ctr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mem_we |=> $stable(ctr_q))
    else $error("stamp counter moved without a write");

  // The size changes only in the write-back cycle.
  a_used_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_WRITE) |=> $stable(used_q))
    else $error("table size changed outside write-back");

  // Outstanding scan reads exist only during the scan.
  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("scan read pending outside scan");

endmodule

// ===== hdl/rut_ram.sv =====
module rut_ram #(
  parameter int unsigned DEPTH = rut_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [rut_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [rut_pkg::WORD_W-1:0] rdata_o
);
  import rut_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
